FILE: rtl/pbd_pkg.sv
// shared constants and types for the protobuf message decoder
package pbd_pkg;

  // longest message taken, in bytes
  localparam int MAX_LEN = 255;

  // byte position counter, saturates at MAX_LEN
  localparam int POS_W = $clog2(MAX_LEN + 1);

  // body skip counter, must hold MAX_LEN and the fixed64 body size
  localparam int SKIP_W = (POS_W > 4) ? POS_W : 4;

  // wire kinds
  localparam logic [2:0] WK_VARINT  = 3'd0;
  localparam logic [2:0] WK_FIXED64 = 3'd1;
  localparam logic [2:0] WK_LENGTH  = 3'd2;
  localparam logic [2:0] WK_FIXED32 = 3'd5;

  // field numbers that are kept
  localparam logic [4:0] FLD_PORT    = 5'd1;
  localparam logic [4:0] FLD_PAYLOAD = 5'd2;
  localparam logic [4:0] FLD_WANT    = 5'd3;
  localparam logic [4:0] FLD_REQ_ID  = 5'd6;

  // varint byte index that may not carry a continuation bit
  localparam logic [2:0] VARINT_LAST_STEP = 3'd4;

  // body sizes of the fixed wire kinds
  localparam int FIXED32_BYTES = 4;
  localparam int FIXED64_BYTES = 8;

  // one decoded message
  typedef struct packed {
    logic        accepted;
    logic [31:0] port_number;
    logic        port_present;
    logic        want_response;
    logic        payload_present;
    logic [7:0]  payload_offset;
    logic [7:0]  payload_length;
    logic [31:0] call_id;
  } result_t;

endpackage

FILE: rtl/pbd_parser.sv
// byte-serial parse state and end-of-message result logic
module pbd_parser
  import pbd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  output result_t       result
);

  // parse phases
  localparam logic [1:0] PH_TAG    = 2'd0;
  localparam logic [1:0] PH_VALUE  = 2'd1;
  localparam logic [1:0] PH_LENGTH = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

  logic [POS_W-1:0]  pos, pos_next;
  logic [1:0]        phase, phase_next;
  logic [4:0]        field, field_next;
  logic [2:0]        wire_kind, wire_kind_next;
  logic [31:0]       acc, acc_next;
  logic [2:0]        step_cnt, step_cnt_next;
  logic [SKIP_W-1:0] skip, skip_next;
  logic              failed, failed_next;
  logic [31:0]       port, port_next;
  logic              has_port, has_port_next;
  logic              want, want_next;
  logic              has_pay, has_pay_next;
  logic [POS_W-1:0]  pay_start, pay_start_next;
  logic [POS_W-1:0]  pay_size, pay_size_next;
  logic [31:0]       req, req_next;

  // working values
  logic [5:0]        shamt;
  logic [31:0]       acc_or;
  logic [POS_W-1:0]  room;
  logic [1:0]        lane;
  logic [SKIP_W-1:0] skip_dec;

  // end-of-message view
  logic              fin_fail;
  logic [31:0]       fin_port;
  logic              fin_has_port;
  logic              fin_want;
  logic              fin_has_pay;
  logic [POS_W-1:0]  fin_start;
  logic [POS_W-1:0]  fin_size;
  logic              ok;

  // shift amount 7 * step, step is at most 4 here
  assign shamt    = {step_cnt, 3'b000} - {3'b000, step_cnt};
  assign acc_or   = acc | (32'(data_byte[6:0]) << shamt);
  assign room     = POS_MAX - pos - POS_W'(1);
  assign lane     = 2'(SKIP_W'(FIXED32_BYTES) - skip);
  assign skip_dec = (skip != '0) ? skip - SKIP_W'(1) : skip;

  // per-byte state update
  always_comb begin
    pos_next       = pos;
    phase_next     = phase;
    field_next     = field;
    wire_kind_next = wire_kind;
    acc_next       = acc;
    step_cnt_next  = step_cnt;
    skip_next      = skip;
    failed_next    = failed;
    port_next      = port;
    has_port_next  = has_port;
    want_next      = want;
    has_pay_next   = has_pay;
    pay_start_next = pay_start;
    pay_size_next  = pay_size;
    req_next       = req;

    if (pos != POS_MAX) begin
      pos_next = pos + POS_W'(1);
    end

    if (!failed) begin
      if (pos == POS_MAX) begin
        failed_next = 1'b1;
      end else begin
        case (phase)
          PH_TAG: begin
            field_next     = data_byte[7:3];
            wire_kind_next = data_byte[2:0];
            acc_next       = '0;
            step_cnt_next  = '0;
            case (data_byte[2:0])
              WK_VARINT: begin
                phase_next = PH_VALUE;
              end
              WK_LENGTH: begin
                phase_next = PH_LENGTH;
              end
              WK_FIXED32: begin
                skip_next  = SKIP_W'(FIXED32_BYTES);
                phase_next = PH_SKIP;
                if (data_byte[7:3] == FLD_REQ_ID) begin
                  req_next = '0;
                end
              end
              WK_FIXED64: begin
                skip_next  = SKIP_W'(FIXED64_BYTES);
                phase_next = PH_SKIP;
              end
              default: begin
                failed_next = 1'b1;
              end
            endcase
          end
          PH_VALUE, PH_LENGTH: begin
            acc_next = acc_or;
            if (!data_byte[7]) begin
              if (phase == PH_VALUE) begin
                // varint value done
                if (field == FLD_PORT) begin
                  port_next     = acc_or;
                  has_port_next = 1'b1;
                end else if (field == FLD_WANT) begin
                  want_next = (acc_or != '0);
                end
                phase_next = PH_TAG;
              end else if (acc_or > 32'(room)) begin
                // body cannot fit in the message
                failed_next = 1'b1;
              end else begin
                if (field == FLD_PAYLOAD) begin
                  pay_start_next = pos + POS_W'(1);
                  pay_size_next  = acc_or[POS_W-1:0];
                  has_pay_next   = 1'b1;
                end
                if (acc_or == '0) begin
                  phase_next = PH_TAG;
                end else begin
                  skip_next  = SKIP_W'(acc_or[POS_W-1:0]);
                  phase_next = PH_SKIP;
                end
              end
            end else begin
              step_cnt_next = step_cnt + 3'd1;
              if (step_cnt == VARINT_LAST_STEP) begin
                failed_next = 1'b1;
              end
            end
          end
          PH_SKIP: begin
            // request id bytes arrive little-endian
            if (wire_kind == WK_FIXED32 && field == FLD_REQ_ID &&
                skip <= SKIP_W'(FIXED32_BYTES) && skip != '0) begin
              req_next = req | (32'(data_byte) << {lane, 3'b000});
            end
            skip_next = skip_dec;
            if (skip_dec == '0) begin
              phase_next = PH_TAG;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  // close out a message that ends on this byte
  always_comb begin
    fin_fail     = failed_next;
    fin_port     = port_next;
    fin_has_port = has_port_next;
    fin_want     = want_next;
    fin_has_pay  = has_pay_next;
    fin_start    = pay_start_next;
    fin_size     = pay_size_next;
    if (!failed_next) begin
      case (phase_next)
        PH_VALUE: begin
          // cut-off varint counts as it stands
          if (field_next == FLD_PORT) begin
            fin_port     = acc_next;
            fin_has_port = 1'b1;
          end else if (field_next == FLD_WANT) begin
            fin_want = (acc_next != '0);
          end
        end
        PH_LENGTH: begin
          // cut-off length is only good when it is still zero
          if (acc_next != '0) begin
            fin_fail = 1'b1;
          end else if (field_next == FLD_PAYLOAD) begin
            fin_start   = pos_next;
            fin_size    = '0;
            fin_has_pay = 1'b1;
          end
        end
        PH_SKIP: begin
          if (skip_next != '0) begin
            fin_fail = 1'b1;
          end
        end
        default: begin
          fin_fail = failed_next;
        end
      endcase
    end
  end

  // result fields, all zero on a failed parse
  assign ok = !fin_fail;
  always_comb begin
    result.accepted        = ok && fin_has_port && (fin_port != '0) && !fin_port[31];
    result.port_number     = ok ? fin_port : '0;
    result.port_present    = ok && fin_has_port;
    result.want_response   = ok && fin_want;
    result.payload_present = ok && fin_has_pay;
    result.payload_offset  = (ok && fin_has_pay) ? 8'(fin_start) : '0;
    result.payload_length  = (ok && fin_has_pay) ? 8'(fin_size) : '0;
    result.call_id         = ok ? req_next : '0;
  end

  // state registers, cleared after every message
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      pos       <= '0;
      phase     <= PH_TAG;
      field     <= '0;
      wire_kind <= '0;
      acc       <= '0;
      step_cnt  <= '0;
      skip      <= '0;
      failed    <= 1'b0;
      port      <= '0;
      has_port  <= 1'b0;
      want      <= 1'b0;
      has_pay   <= 1'b0;
      pay_start <= '0;
      pay_size  <= '0;
      req       <= '0;
    end else if (step) begin
      pos       <= pos_next;
      phase     <= phase_next;
      field     <= field_next;
      wire_kind <= wire_kind_next;
      acc       <= acc_next;
      step_cnt  <= step_cnt_next;
      skip      <= skip_next;
      failed    <= failed_next;
      port      <= port_next;
      has_port  <= has_port_next;
      want      <= want_next;
      has_pay   <= has_pay_next;
      pay_start <= pay_start_next;
      pay_size  <= pay_size_next;
      req       <= req_next;
    end
  end

  // a message end always returns the parser to a clean start
  a_clean_after_last: assert property (@(posedge clk) disable iff (rst)
    step && last_byte |=> pos == '0 && phase == PH_TAG && !failed && !has_port)
    else $error("parser state not cleared after last item");

  // a body being skipped always has bytes left
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP && !failed |-> skip != '0)
    else $error("skip phase with nothing left to skip");

  // varint step index stays within five bytes while parsing
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    !failed |-> step_cnt <= VARINT_LAST_STEP)
    else $error("varint step past fifth byte");

  // a recorded payload always lies inside the message
  a_payload_fits: assert property (@(posedge clk) disable iff (rst)
    has_pay && !failed |-> 32'(pay_start) + 32'(pay_size) <= 32'(MAX_LEN))
    else $error("payload runs past message limit");

endmodule

FILE: rtl/pbd_result_reg.sv
// output register for decoded message results
module pbd_result_reg
  import pbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t result_out
);

  // valid flag: set on load, cleared when the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

FILE: rtl/protobuf_data_message_decoder_top.sv
// Protobuf wire-format message decoder, one byte per item, one result per message.
// Takes one encoded byte per cycle and returns one result item on the byte marked
// last_byte; a byte passes through the input register, and the result of a last
// byte is loaded into the output register as that byte leaves the input register.
// Sustained rate is one byte per clock: the parse state updates in a single pass
// per byte. Input stalls only when a last byte waits on a result that has not yet
// been taken. Messages longer than MAX_LEN bytes, bad wire kinds, over-long varints
// and bodies that run past the end are reported with accepted low and all other
// fields zero.
module protobuf_data_message_decoder_top
  import pbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic [31:0] port_number,
  output logic        port_present,
  output logic        want_response,
  output logic        payload_present,
  output logic [7:0]  payload_offset,
  output logic [7:0]  payload_length,
  output logic [31:0] call_id
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_go;
  logic       in_take;
  result_t    parse_res;
  result_t    out_res;

  // input register advances unless a last item waits on a full output
  assign s1_go    = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  // parse state
  pbd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_go),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .result    (parse_res)
  );

  // result register
  pbd_result_reg u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_go && s1_last),
    .result_in  (parse_res),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .result_out (out_res)
  );

  assign accepted        = out_res.accepted;
  assign port_number     = out_res.port_number;
  assign port_present    = out_res.port_present;
  assign want_response   = out_res.want_response;
  assign payload_present = out_res.payload_present;
  assign payload_offset  = out_res.payload_offset;
  assign payload_length  = out_res.payload_length;
  assign call_id         = out_res.call_id;

  // a last item held back keeps its place until the result is taken
  a_last_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last && out_valid && out_stall |=> s1_valid && s1_last)
    else $error("held last item lost from input register");

  // a result is never overwritten while it waits to be taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(s1_go && s1_last))
    else $error("result overwritten while stalled");

endmodule
